// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker file of the codec.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define TQC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TQC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define TQC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tqc_pkg.sv -----
// ----------------------------------------------------------------------------
// Transform quantize codec package
// Beat types and fixed arithmetic widths shared by the codec modules.
// ----------------------------------------------------------------------------
package tqc_pkg;

  // Opcode values carried in the top bit of the input beat.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Square root: 64-bit radicand, 32-bit root, pipelined over SQRT_STAGES.
  localparam int unsigned RAD_BITS    = 64;
  localparam int unsigned ROOT_BITS   = 32;
  localparam int unsigned SQRT_STAGES = 8;

  // Component magnitudes are Q.30 with a maximum of exactly one.
  localparam int unsigned COMP_BITS = 31;
  localparam logic [COMP_BITS-1:0] ONE_Q30 = 31'h4000_0000;

  // Division lane: one set-up stage and then quotient stages.
  localparam int unsigned DIV_STAGES     = 6;
  localparam int unsigned DIV_QUO_BITS   = 20;
  localparam int unsigned QUAT_FRAC_BITS = 15;

  // The dropped index sits at the top of the rotation word.
  localparam int unsigned INDEX_LSB = 30;

  typedef struct packed {
    logic                neg;
    logic [COMP_BITS-1:0] mag;
  } comp_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] code_x;
    logic signed [15:0] code_y;
    logic signed [15:0] code_z;
    logic [31:0]        packed_rotation;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_code_x;
    logic signed [15:0] out_code_y;
    logic signed [15:0] out_code_z;
    logic [31:0]        out_packed_rotation;
    logic signed [31:0] out_position_x;
    logic signed [31:0] out_position_y;
    logic signed [31:0] out_position_z;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic signed [15:0] out_quat_w;
  } out_beat_t;

endpackage

// ----- rtl/tqc_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit radicand, a few root bits per stage.
// ----------------------------------------------------------------------------
module tqc_isqrt
  import tqc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [RAD_BITS-1:0]  rad_i,
  output logic [ROOT_BITS-1:0] root_o
);

  localparam int unsigned STEPS    = ROOT_BITS / SQRT_STAGES;
  localparam int unsigned REM_BITS = ROOT_BITS + 4;

  typedef struct packed {
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_state_t;

  sqrt_state_t stage_d [SQRT_STAGES];
  sqrt_state_t stage_q [SQRT_STAGES];

  always_comb begin
    sqrt_state_t         st;
    logic [REM_BITS-1:0] shifted;
    logic [REM_BITS-1:0] trial;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        st = '{rad: rad_i, rem: '0, root: '0};
      end else begin
        st = stage_q[s-1];
      end
      for (int k = 0; k < STEPS; k++) begin
        shifted = {st.rem[REM_BITS-3:0], st.rad[RAD_BITS-1 -: 2]};
        trial   = REM_BITS'({st.root, 2'b01});
        if (shifted >= trial) begin
          st.rem  = shifted - trial;
          st.root = {st.root[ROOT_BITS-2:0], 1'b1};
        end else begin
          st.rem  = shifted;
          st.root = {st.root[ROOT_BITS-2:0], 1'b0};
        end
        st.rad = {st.rad[RAD_BITS-3:0], 2'b00};
      end
      stage_d[s] = st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign root_o = stage_q[SQRT_STAGES-1].root;

endmodule

// ----- rtl/tqc_div_lane.sv -----
// ----------------------------------------------------------------------------
// Renormalising division lane
// Scales one component to Q1.15 by the quaternion length, rounded and
// saturated, with a restoring divider spread over several stages.
// ----------------------------------------------------------------------------
module tqc_div_lane
  import tqc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  en_i,
  input  comp_t                 comp_i,
  input  logic [ROOT_BITS-1:0]  len_i,
  output logic signed [15:0]    quat_o
);

  localparam int unsigned NUM_BITS    = COMP_BITS + QUAT_FRAC_BITS + 1;
  localparam int unsigned REM_BITS    = ROOT_BITS + 1;
  localparam int unsigned STEP_STAGES = DIV_STAGES - 1;
  localparam int unsigned STEPS       = DIV_QUO_BITS / STEP_STAGES;

  typedef struct packed {
    logic                    neg;
    logic [ROOT_BITS-1:0]    len;
    logic [REM_BITS-1:0]     rem;
    logic [DIV_QUO_BITS-1:0] quo;
  } div_state_t;

  logic [NUM_BITS-1:0] num_d;
  div_state_t          setup_d;
  div_state_t          setup_q;
  div_state_t          stage_d [STEP_STAGES];
  div_state_t          stage_q [STEP_STAGES];

  // Rounded numerator; the low bits ride in the quotient register and are
  // shifted out as quotient bits come in.
  always_comb begin
    num_d = (NUM_BITS'(comp_i.mag) << QUAT_FRAC_BITS) + NUM_BITS'(len_i >> 1);
    setup_d.neg = comp_i.neg;
    setup_d.len = len_i;
    setup_d.rem = REM_BITS'(num_d >> DIV_QUO_BITS);
    setup_d.quo = num_d[DIV_QUO_BITS-1:0];
  end

  always_comb begin
    div_state_t          st;
    logic [REM_BITS-1:0] shifted;
    for (int s = 0; s < STEP_STAGES; s++) begin
      if (s == 0) begin
        st = setup_q;
      end else begin
        st = stage_q[s-1];
      end
      for (int k = 0; k < STEPS; k++) begin
        shifted = {st.rem[REM_BITS-2:0], st.quo[DIV_QUO_BITS-1]};
        if (shifted >= REM_BITS'(st.len)) begin
          st.rem = shifted - REM_BITS'(st.len);
          st.quo = {st.quo[DIV_QUO_BITS-2:0], 1'b1};
        end else begin
          st.rem = shifted;
          st.quo = {st.quo[DIV_QUO_BITS-2:0], 1'b0};
        end
      end
      stage_d[s] = st;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      setup_q <= setup_d;
      for (int s = 0; s < STEP_STAGES; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  // Saturate to the int16 range; a positive full unit reads as 32767.
  always_comb begin
    logic [DIV_QUO_BITS-1:0] q;
    q = stage_q[STEP_STAGES-1].quo;
    if (stage_q[STEP_STAGES-1].neg) begin
      if (q > DIV_QUO_BITS'(32768)) begin
        quat_o = 16'sh8000;
      end else begin
        quat_o = 16'd0 - q[15:0];
      end
    end else begin
      if (q > DIV_QUO_BITS'(32767)) begin
        quat_o = 16'sh7fff;
      end else begin
        quat_o = q[15:0];
      end
    end
  end

endmodule

// ----- rtl/tqc_delay.sv -----
// ----------------------------------------------------------------------------
// Sideband delay line
// Carries payload alongside the arithmetic units, one register per stage.
// ----------------------------------------------------------------------------
module tqc_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] stage_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q[0] <= data_i;
      for (int s = 1; s < DEPTH; s++) begin
        stage_q[s] <= stage_q[s-1];
      end
    end
  end

  assign data_o = stage_q[DEPTH-1];

endmodule

// ----- rtl/transform_quantize_codec_top.sv -----
// ----------------------------------------------------------------------------
// Transform quantize codec, top level
// The two square roots and the division lanes sit in series in the pipeline.
// Throughput: one beat per cycle; the whole pipeline holds while an output
// beat waits.
// Reset clears the pipeline valid bits and loads the default scale registers.
// ----------------------------------------------------------------------------
module transform_quantize_codec_top
  import tqc_pkg::*;
#(
  parameter int POSITION_CODE_LIMIT = 32767,
  parameter int ROTATION_CODE_LIMIT = 511,
  parameter int ROTATION_FIELD_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The pipeline runs in three parts. The front end (five stages) does the
  // whole of encoding and the position half of decoding, and turns the
  // received rotation fields into signed Q.30 components and their squares.
  // The decode path then takes a square root to rebuild the dropped
  // component, a second square root for the length, and four division lanes,
  // one per component, renormalise in parallel. A final mux merges the lanes
  // with the front-end results into the output register.

  localparam int unsigned FB          = ROTATION_FIELD_BITS;
  localparam int unsigned FRONT_DEPTH = 5;
  localparam int unsigned PIPE_DEPTH  = FRONT_DEPTH + SQRT_STAGES + 2 + SQRT_STAGES
                                        + DIV_STAGES;

  localparam logic signed [16:0] PLIM     = 17'(POSITION_CODE_LIMIT);
  localparam logic signed [16:0] PLIM_NEG = 17'(-POSITION_CODE_LIMIT);
  localparam logic signed [11:0] RLIM     = 12'(ROTATION_CODE_LIMIT);
  localparam logic signed [11:0] RLIM_NEG = 12'(-ROTATION_CODE_LIMIT);
  localparam logic [63:0]        ONE_Q60  = 64'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_POSITION_SCALE,
    REG_METRES_PER_CODE,
    REG_ROTATION_SCALE,
    REG_UNIT_PER_ROT_CODE
  } reg_idx_e;

  typedef struct packed {
    logic              opcode;
    logic [2:0][15:0]  enc_code;
    logic [31:0]       enc_word;
    logic [2:0][31:0]  dec_pos;
  } side_t;

  typedef struct packed {
    side_t       side;
    comp_t [3:0] comps;
    logic [62:0] sum;
    logic [1:0]  drop;
  } front_t;

  typedef struct packed {
    side_t       side;
    comp_t [3:0] comps;
  } mid_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes land in the access phase; pready is tied
  // high, so no access is ever extended by wait states.
  // --------------------------------------------------------------------------
  logic [31:0] pos_scale_q;
  logic [31:0] metres_q;
  logic [31:0] rot_scale_q;
  logic [31:0] unit_q;
  reg_idx_e    reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_scale_q <= 32'd2097152;
      metres_q    <= 32'd2048;
      rot_scale_q <= 32'd47361536;
      unit_q      <= 32'd5943275;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_POSITION_SCALE:    pos_scale_q <= pwdata;
        REG_METRES_PER_CODE:   metres_q    <= pwdata;
        REG_ROTATION_SCALE:    rot_scale_q <= pwdata;
        REG_UNIT_PER_ROT_CODE: unit_q      <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POSITION_SCALE:    prdata = pos_scale_q;
      REG_METRES_PER_CODE:   prdata = metres_q;
      REG_ROTATION_SCALE:    prdata = rot_scale_q;
      REG_UNIT_PER_ROT_CODE: prdata = unit_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control. Every stage moves together; the pipeline only holds when
  // the output register is full and its beat is not being taken.
  // --------------------------------------------------------------------------
  logic                  adv;
  logic [PIPE_DEPTH-1:0] valid_q;
  logic                  out_valid_q;
  out_beat_t             out_q;
  out_beat_t             out_d;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[PIPE_DEPTH-2:0], in_valid_i};
      out_valid_q <= valid_q[PIPE_DEPTH-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register.
  // --------------------------------------------------------------------------
  in_beat_t in_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sign and magnitude split, the largest quaternion component, and
  // all the scale products.
  // --------------------------------------------------------------------------
  logic [31:0]       pos_in  [3];
  logic [15:0]       quat_in [4];
  logic [15:0]       code_in [3];
  logic [16:0]       qmag    [4];
  logic [1:0]        lg_d;

  logic [63:0]       enc_prod_d [3];
  logic [2:0]        enc_neg_d;
  logic [46:0]       rot_prod_d [4];
  logic [3:0]        rot_neg_d;
  logic [46:0]       dpos_prod_d [3];
  logic [2:0]        dpos_neg_d;
  logic [40:0]       fld_prod_d [3];
  logic [2:0]        fld_neg_d;

  logic [63:0]       enc_prod_q [3];
  logic [2:0]        enc_neg_q;
  logic [46:0]       rot_prod_q [4];
  logic [3:0]        rot_neg_q;
  logic [1:0]        lg_q;
  logic [46:0]       dpos_prod_q [3];
  logic [2:0]        dpos_neg_q;
  logic [40:0]       fld_prod_q [3];
  logic [2:0]        fld_neg_q;
  logic [1:0]        drop2_q;
  logic              op2_q;

  assign pos_in[0]  = in_q.position_x;
  assign pos_in[1]  = in_q.position_y;
  assign pos_in[2]  = in_q.position_z;
  assign quat_in[0] = in_q.quat_x;
  assign quat_in[1] = in_q.quat_y;
  assign quat_in[2] = in_q.quat_z;
  assign quat_in[3] = in_q.quat_w;
  assign code_in[0] = in_q.code_x;
  assign code_in[1] = in_q.code_y;
  assign code_in[2] = in_q.code_z;

  always_comb begin
    logic [31:0] mag;
    for (int a = 0; a < 3; a++) begin
      enc_neg_d[a]  = pos_in[a][31];
      mag           = pos_in[a][31] ? (~pos_in[a] + 32'd1) : pos_in[a];
      enc_prod_d[a] = 64'(mag) * 64'(pos_scale_q);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmag[i] = quat_in[i][15] ? (17'd0 - 17'({1'b1, quat_in[i]})) : 17'(quat_in[i]);
    end
  end

  // Ties keep the lower index, as only a strictly larger one takes over.
  always_comb begin
    lg_d = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (qmag[i] > qmag[lg_d]) begin
        lg_d = 2'(i);
      end
    end
  end

  // Negating the whole quaternion flips every sign but leaves magnitudes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rot_neg_d[i]  = quat_in[i][15] ^ quat_in[lg_d][15];
      rot_prod_d[i] = 47'(48'(qmag[i]) * 48'(rot_scale_q));
    end
  end

  always_comb begin
    logic signed [16:0] c;
    for (int a = 0; a < 3; a++) begin
      c = 17'($signed(code_in[a]));
      if (c > PLIM) begin
        c = PLIM;
      end else if (c < PLIM_NEG) begin
        c = PLIM_NEG;
      end
      dpos_neg_d[a]  = c[16];
      dpos_prod_d[a] = 47'(15'(c[16] ? (17'd0 - c) : c)) * 47'(metres_q);
    end
  end

  always_comb begin
    logic signed [11:0] fcode;
    for (int f = 0; f < 3; f++) begin
      fcode = 12'(in_q.packed_rotation[f*FB +: FB]) - 12'(ROTATION_CODE_LIMIT);
      if (fcode > RLIM) begin
        fcode = RLIM;
      end else if (fcode < RLIM_NEG) begin
        fcode = RLIM_NEG;
      end
      fld_neg_d[f]  = fcode[11];
      fld_prod_d[f] = 41'(9'(fcode[11] ? (12'd0 - fcode) : fcode)) * 41'(unit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      enc_prod_q  <= enc_prod_d;
      enc_neg_q   <= enc_neg_d;
      rot_prod_q  <= rot_prod_d;
      rot_neg_q   <= rot_neg_d;
      lg_q        <= lg_d;
      dpos_prod_q <= dpos_prod_d;
      dpos_neg_q  <= dpos_neg_d;
      fld_prod_q  <= fld_prod_d;
      fld_neg_q   <= fld_neg_d;
      drop2_q     <= in_q.packed_rotation[INDEX_LSB +: 2];
      op2_q       <= in_q.opcode;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: rounding and clamping. Encode finishes here with the rotation
  // word; decoded fields become Q.30 components in their own places.
  // --------------------------------------------------------------------------
  side_t       side3_d;
  comp_t [3:0] comps3_d;
  side_t       side3_q;
  comp_t [3:0] comps3_q;
  logic [1:0]  drop3_q;

  always_comb begin
    side3_d.opcode = op2_q;

    begin : enc_position
      logic [63:0] rnd;
      logic [15:0] q16;
      for (int a = 0; a < 3; a++) begin
        rnd = enc_prod_q[a] + 64'h8000_0000;
        if (rnd[63:32] > 32'(POSITION_CODE_LIMIT)) begin
          q16 = 16'(POSITION_CODE_LIMIT);
        end else begin
          q16 = rnd[47:32];
        end
        side3_d.enc_code[a] = enc_neg_q[a] ? (16'd0 - q16) : q16;
      end
    end

    // Kept components fill the fields in index order, the first lowest.
    begin : enc_rotation
      logic [47:0]    rnd;
      logic [11:0]    q12;
      logic [11:0]    biased [4];
      logic [1:0]     src;
      for (int i = 0; i < 4; i++) begin
        rnd = 48'(rot_prod_q[i]) + 48'h4000_0000;
        if (rnd[47:31] > 17'(ROTATION_CODE_LIMIT)) begin
          q12 = 12'(ROTATION_CODE_LIMIT);
        end else begin
          q12 = rnd[42:31];
        end
        biased[i] = (rot_neg_q[i] ? (12'd0 - q12) : q12) + 12'(ROTATION_CODE_LIMIT);
      end
      side3_d.enc_word = '0;
      side3_d.enc_word[INDEX_LSB +: 2] = lg_q;
      for (int f = 0; f < 3; f++) begin
        src = (2'(f) < lg_q) ? 2'(f) : 2'(f + 1);
        side3_d.enc_word[f*FB +: FB] = biased[src][FB-1:0];
      end
    end

    for (int a = 0; a < 3; a++) begin
      if (!dpos_neg_q[a]) begin
        side3_d.dec_pos[a] = (dpos_prod_q[a] > 47'h7fff_ffff) ? 32'h7fff_ffff
                                                             : dpos_prod_q[a][31:0];
      end else begin
        side3_d.dec_pos[a] = (dpos_prod_q[a] > 47'h8000_0000) ? 32'h8000_0000
                                                             : (32'd0 - dpos_prod_q[a][31:0]);
      end
    end
  end

  always_comb begin
    logic [41:0]          rnd;
    logic [COMP_BITS-1:0] fmag [3];
    logic [1:0]           f;
    for (int k = 0; k < 3; k++) begin
      rnd = 42'(fld_prod_q[k]) + 42'd2;
      if (rnd[41:2] > 40'(ONE_Q30)) begin
        fmag[k] = ONE_Q30;
      end else begin
        fmag[k] = rnd[32:2];
      end
    end
    for (int i = 0; i < 4; i++) begin
      f = (2'(i) < drop2_q) ? 2'(i) : 2'(i - 1);
      if (2'(i) == drop2_q) begin
        comps3_d[i] = '{neg: 1'b0, mag: '0};
      end else begin
        comps3_d[i] = '{neg: fld_neg_q[f], mag: fmag[f]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q  <= side3_d;
      comps3_q <= comps3_d;
      drop3_q  <= drop2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: squares in Q.60, their sum, and what is left of one.
  // --------------------------------------------------------------------------
  logic [61:0] sq4_q [4];
  side_t       side4_q;
  comp_t [3:0] comps4_q;
  logic [1:0]  drop4_q;
  logic [62:0] sum5_d;
  front_t      front5_q;
  logic [63:0] rad5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq4_q[i] <= 62'(comps3_q[i].mag) * 62'(comps3_q[i].mag);
      end
      side4_q  <= side3_q;
      comps4_q <= comps3_q;
      drop4_q  <= drop3_q;
    end
  end

  assign sum5_d = 63'(sq4_q[0]) + 63'(sq4_q[1]) + 63'(sq4_q[2]) + 63'(sq4_q[3]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      front5_q <= '{side: side4_q, comps: comps4_q, sum: sum5_d, drop: drop4_q};
      rad5_q   <= (64'(sum5_d) < ONE_Q60) ? (ONE_Q60 - 64'(sum5_d)) : 64'd0;
    end
  end

  // --------------------------------------------------------------------------
  // First square root rebuilds the dropped component.
  // --------------------------------------------------------------------------
  logic [ROOT_BITS-1:0] drop_root;
  front_t               front13;

  tqc_isqrt u_drop_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad5_q),
    .root_o (drop_root)
  );

  tqc_delay #(
    .WIDTH ($bits(front_t)),
    .DEPTH (SQRT_STAGES)
  ) u_front_dly (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (front5_q),
    .data_o (front13)
  );

  // --------------------------------------------------------------------------
  // Stages 14 and 15: square of the rebuilt component and the squared length.
  // --------------------------------------------------------------------------
  logic [61:0] rsq14_q;
  logic [62:0] sum14_q;
  mid_t        mid14_d;
  mid_t        mid14_q;
  mid_t        mid15_q;
  logic [63:0] len2_q;

  always_comb begin
    mid14_d.side  = front13.side;
    mid14_d.comps = front13.comps;
    mid14_d.comps[front13.drop] = '{neg: 1'b0, mag: drop_root[COMP_BITS-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsq14_q <= 62'(drop_root[COMP_BITS-1:0]) * 62'(drop_root[COMP_BITS-1:0]);
      sum14_q <= front13.sum;
      mid14_q <= mid14_d;
      len2_q  <= 64'(sum14_q) + 64'(rsq14_q);
      mid15_q <= mid14_q;
    end
  end

  // --------------------------------------------------------------------------
  // Second square root gives the length; the lanes then divide by it.
  // --------------------------------------------------------------------------
  logic [ROOT_BITS-1:0] len_root;
  logic [ROOT_BITS-1:0] len_safe;
  mid_t                 mid23;
  side_t                side29;
  logic signed [15:0]   lane_quat [4];

  tqc_isqrt u_len_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (len2_q),
    .root_o (len_root)
  );

  tqc_delay #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (SQRT_STAGES)
  ) u_mid_dly (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (mid15_q),
    .data_o (mid23)
  );

  // A zero length cannot arise from clamped components; it reads as one LSB.
  assign len_safe = (len_root == '0) ? ROOT_BITS'(1) : len_root;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    tqc_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .comp_i (mid23.comps[i]),
      .len_i  (len_safe),
      .quat_o (lane_quat[i])
    );
  end

  tqc_delay #(
    .WIDTH ($bits(side_t)),
    .DEPTH (DIV_STAGES)
  ) u_side_dly (
    .clk_i  (clk_i),
    .en_i   (adv),
    .data_i (mid23.side),
    .data_o (side29)
  );

  // --------------------------------------------------------------------------
  // Merge: the unused half of the output beat reads as zero.
  // --------------------------------------------------------------------------
  always_comb begin
    out_d = '0;
    if (side29.opcode == OP_ENCODE) begin
      out_d.out_code_x          = side29.enc_code[0];
      out_d.out_code_y          = side29.enc_code[1];
      out_d.out_code_z          = side29.enc_code[2];
      out_d.out_packed_rotation = side29.enc_word;
    end else begin
      out_d.out_position_x = side29.dec_pos[0];
      out_d.out_position_y = side29.dec_pos[1];
      out_d.out_position_z = side29.dec_pos[2];
      out_d.out_quat_x     = lane_quat[0];
      out_d.out_quat_y     = lane_quat[1];
      out_d.out_quat_z     = lane_quat[2];
      out_d.out_quat_w     = lane_quat[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/tqc_checker.sv -----
// ----------------------------------------------------------------------------
// Transform quantize codec checker
// Port-level assertions on the codec, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tqc_checker
  import tqc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_beat_t   out_data_o
);

  // A waiting output beat stays, unchanged.
  `TQC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped")
  `TQC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "output beat changed")

  // The pipeline takes a beat whenever its output register can move.
  `TQC_ASSERT(a_in_ready, in_ready_o == (!out_valid_o || out_ready_i), "input ready mismatch")

  // A non-zero rotation word marks an encode result, whose position x and quat w are zero.
  `TQC_ASSERT_IMP(a_encode_excl, out_valid_o && (out_data_o.out_packed_rotation != 32'd0), (out_data_o.out_position_x == 32'sd0) && (out_data_o.out_quat_w == 16'sd0), "encode beat has decode fields")

endmodule

bind transform_quantize_codec_top tqc_checker u_checker (.*);

// ----- verif/tb_transform_quantize_codec_top.sv -----
// ----------------------------------------------------------------------------
// Transform quantize codec testbench
// Streams encode and decode beats through the codec under several scale
// settings, with random gaps on both sides and one long output stall, and
// checks every output beat against a bit-exact model held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_transform_quantize_codec_top;
  import tqc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes of the configuration port.
  localparam int REG_POSITION_SCALE  = 0;
  localparam int REG_METRES_PER_CODE = 1;
  localparam int REG_ROTATION_SCALE  = 2;
  localparam int REG_UNIT_PER_CODE   = 3;
  localparam int NUM_REGS            = 4;

  localparam int POS_LIMIT   = 32767;
  localparam int ROT_LIMIT   = 511;
  localparam int FIELD_BITS  = 10;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LEN   = 200;
  localparam int PHASE_BEATS = 170;

  // The scoreboard keeps its own copy of the scale registers, predicts the
  // output beat of every accepted input beat and checks beats in order.
  class codec_scoreboard;
    logic [31:0] regs [NUM_REGS];
    out_beat_t   pending_transforms [$];
    int          errors;
    int          n_checked;

    function new();
      regs[REG_POSITION_SCALE]  = 32'd2097152;
      regs[REG_METRES_PER_CODE] = 32'd2048;
      regs[REG_ROTATION_SCALE]  = 32'd47361536;
      regs[REG_UNIT_PER_CODE]   = 32'd5943275;
      errors    = 0;
      n_checked = 0;
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic logic [15:0] encode_position(logic signed [31:0] p);
      longint unsigned mag, q;
      mag = (p < 0) ? longint'(-longint'(p)) : longint'(p);
      q = (mag * longint'(regs[REG_POSITION_SCALE]) + 64'h8000_0000) >> 32;
      if (q > POS_LIMIT) q = POS_LIMIT;
      return (p < 0) ? 16'(-int'(q)) : 16'(q);
    endfunction

    function automatic logic [31:0] pack_rotation(in_beat_t b);
      int c [4];
      int largest, v, code, shift;
      longint unsigned q;
      logic [31:0] word;
      bit neg;
      c[0] = b.quat_x; c[1] = b.quat_y; c[2] = b.quat_z; c[3] = b.quat_w;
      largest = 0;
      shift = 0;
      for (int i = 1; i < 4; i++)
        if ((c[i] < 0 ? -c[i] : c[i]) > (c[largest] < 0 ? -c[largest] : c[largest]))
          largest = i;
      neg  = c[largest] < 0;
      word = 32'(largest) << INDEX_LSB;
      for (int i = 0; i < 4; i++) begin
        if (i != largest) begin
          v = neg ? -c[i] : c[i];
          q = (longint'(v < 0 ? -v : v) * longint'(regs[REG_ROTATION_SCALE])
               + 64'h4000_0000) >> 31;
          if (q > ROT_LIMIT) q = ROT_LIMIT;
          code = (v < 0) ? -int'(q) : int'(q);
          word |= (32'(code + ROT_LIMIT) & ((32'd1 << FIELD_BITS) - 1)) << shift;
          shift += FIELD_BITS;
        end
      end
      return word;
    endfunction

    function automatic logic [31:0] decode_position(logic signed [15:0] raw);
      longint code, p;
      code = raw;
      if (code > POS_LIMIT) code = POS_LIMIT;
      if (code < -POS_LIMIT) code = -POS_LIMIT;
      p = code * longint'(regs[REG_METRES_PER_CODE]);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return 32'(p);
    endfunction

    // Rebuilds the dropped component in Q.30 and renormalises all four to Q1.15.
    function automatic void unpack_rotation(logic [31:0] word, ref out_beat_t o);
      longint c [4];
      longint unsigned m, sum, rest, len, q;
      int largest, code, shift;
      logic [15:0] r [4];
      largest = word[31:30];
      shift = 0;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        c[i] = 0;
        if (i != largest) begin
          code = int'((word >> shift) & ((32'd1 << FIELD_BITS) - 1)) - ROT_LIMIT;
          shift += FIELD_BITS;
          if (code > ROT_LIMIT) code = ROT_LIMIT;
          if (code < -ROT_LIMIT) code = -ROT_LIMIT;
          m = (longint'(code < 0 ? -code : code) * longint'(regs[REG_UNIT_PER_CODE]) + 2) >> 2;
          if (m > 64'd1073741824) m = 64'd1073741824;
          c[i] = (code < 0) ? -longint'(m) : longint'(m);
          sum += m * m;
        end
      end
      rest = (sum < (64'd1 << 60)) ? (64'd1 << 60) - sum : 0;
      c[largest] = root64(rest);
      len = root64(sum + longint'(c[largest]) * longint'(c[largest]));
      if (len == 0) len = 1;
      for (int i = 0; i < 4; i++) begin
        q = ((longint'(c[i] < 0 ? -c[i] : c[i]) << QUAT_FRAC_BITS) + (len >> 1)) / len;
        if (c[i] < 0) r[i] = (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        else          r[i] = (q > 32767) ? 16'h7fff : 16'(q);
      end
      o.out_quat_x = r[0]; o.out_quat_y = r[1]; o.out_quat_z = r[2]; o.out_quat_w = r[3];
    endfunction

    function automatic out_beat_t quantize_transform(in_beat_t b);
      out_beat_t o;
      o = '0;
      if (b.opcode == OP_ENCODE) begin
        o.out_code_x = encode_position(b.position_x);
        o.out_code_y = encode_position(b.position_y);
        o.out_code_z = encode_position(b.position_z);
        o.out_packed_rotation = pack_rotation(b);
      end else begin
        o.out_position_x = decode_position(b.code_x);
        o.out_position_y = decode_position(b.code_y);
        o.out_position_z = decode_position(b.code_z);
        unpack_rotation(b.packed_rotation, o);
      end
      return o;
    endfunction

    function void note_input(in_beat_t b);
      pending_transforms.push_back(quantize_transform(b));
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_output(out_beat_t a);
      out_beat_t e;
      if (pending_transforms.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending_transforms.pop_front();
      n_checked++;
      compare_field("out_code_x", 32'(e.out_code_x), 32'(a.out_code_x));
      compare_field("out_code_y", 32'(e.out_code_y), 32'(a.out_code_y));
      compare_field("out_code_z", 32'(e.out_code_z), 32'(a.out_code_z));
      compare_field("out_packed_rotation", e.out_packed_rotation, a.out_packed_rotation);
      compare_field("out_position_x", e.out_position_x, a.out_position_x);
      compare_field("out_position_y", e.out_position_y, a.out_position_y);
      compare_field("out_position_z", e.out_position_z, a.out_position_z);
      compare_field("out_quat_x", 32'(e.out_quat_x), 32'(a.out_quat_x));
      compare_field("out_quat_y", 32'(e.out_quat_y), 32'(a.out_quat_y));
      compare_field("out_quat_z", 32'(e.out_quat_z), 32'(a.out_quat_z));
      compare_field("out_quat_w", 32'(e.out_quat_w), 32'(a.out_quat_w));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_beat_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_beat_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  codec_scoreboard sb = new();

  // Shared between the sender and the receiver: the count of accepted input
  // beats, and a flag that switches random idling off for a while.
  int accepted_beats = 0;
  int n_encode = 0;
  int n_decode = 0;
  int n_writes = 0;
  bit calm = 1'b0;

  transform_quantize_codec_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Every output beat taken at a rising edge is checked against the oldest
  // prediction. Values are read before the edge's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_output(out_data_o);
  end

  // The receiver idles at random, except during the calm stretch. Once, after
  // a few hundred beats have gone in, it holds off for a long stretch so that
  // the pipeline fills and the input side is pushed back.
  initial begin : receiver
    int  hold_left;
    bit  stall_done;
    hold_left  = 0;
    stall_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (!stall_done && accepted_beats >= 300) begin
        stall_done  = 1'b1;
        hold_left   = STALL_LEN - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // A generous limit on the whole run; a correct run ends long before.
  initial begin : watchdog
    #5_000_000;
    $display("tb_transform_quantize_codec_top: errors");
    $finish;
  end

  // Offers one beat, with an optional random gap first, and returns at the
  // falling edge after it has been accepted. The scoreboard hears of the
  // beat at the very edge that accepted it.
  task automatic send_beat(in_beat_t b);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(b);
    accepted_beats++;
    if (b.opcode == OP_ENCODE) n_encode++;
    else n_decode++;
    @(negedge clk_i);
  endtask

  // Waits until every predicted beat has come out, then a little longer.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_transforms.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // One register write: a setup phase and then an access phase.
  task automatic write_reg(int idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 4'(idx * 4);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.regs[idx] = value;
    n_writes++;
  endtask

  function automatic in_beat_t make_encode(int px, int py, int pz,
                                           int qx, int qy, int qz, int qw);
    in_beat_t b;
    b = '0;
    b.opcode = OP_ENCODE;
    b.position_x = px; b.position_y = py; b.position_z = pz;
    b.quat_x = 16'(qx); b.quat_y = 16'(qy); b.quat_z = 16'(qz); b.quat_w = 16'(qw);
    return b;
  endfunction

  function automatic in_beat_t make_decode(int cx, int cy, int cz, logic [31:0] word);
    in_beat_t b;
    b = '0;
    b.opcode = OP_DECODE;
    b.code_x = 16'(cx); b.code_y = 16'(cy); b.code_z = 16'(cz);
    b.packed_rotation = word;
    return b;
  endfunction

  // Random beats: every field is random, then about half of them are reshaped
  // into plausible values so that rounding rather than clamping is exercised.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int m;
    b = $bits(in_beat_t)'({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(1)) begin
      b.position_x = $urandom_range(0, 4_000_000) * ($urandom_range(1) ? 1 : -1);
      b.position_y = $urandom_range(0, 4_000_000) * ($urandom_range(1) ? 1 : -1);
      b.position_z = $urandom_range(0, 4_000_000) * ($urandom_range(1) ? 1 : -1);
      b.quat_x = 16'($urandom_range(0, 20000) * ($urandom_range(1) ? 1 : -1));
      b.quat_y = 16'($urandom_range(0, 20000) * ($urandom_range(1) ? 1 : -1));
      b.quat_z = 16'($urandom_range(0, 20000) * ($urandom_range(1) ? 1 : -1));
      b.quat_w = 16'($urandom_range(0, 32767) * ($urandom_range(1) ? 1 : -1));
      // Now and then two components share the largest magnitude.
      if ($urandom_range(7) == 0) begin
        m = $urandom_range(20001, 32767);
        b.quat_y = 16'(m);
        b.quat_w = 16'(-m);
      end
      b.code_x = 16'($urandom_range(0, 2000) - 1000);
      b.packed_rotation[29:0] = {10'($urandom_range(0, 1022)), 10'($urandom_range(0, 1022)),
                                 10'($urandom_range(0, 1022))};
    end
    return b;
  endfunction

  initial begin : stimulus
    logic [31:0] setting [NUM_REGS];
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats under the reset settings. Position 1024 is half a code
    // at the default scale, so it checks rounding of halves away from zero.
    send_beat(make_encode(0, 2147483647, -2147483648, 0, 0, 0, 0));
    send_beat(make_encode(1024, -1024, 1023, 32767, 0, 0, 0));
    send_beat(make_encode(65536, -65536, 3, -32768, 100, -100, 5));
    send_beat(make_encode(0, 0, 0, 16384, 16384, 16384, 16384));   // four-way tie
    send_beat(make_encode(0, 0, 0, -16384, 16384, -16384, 16384)); // tie, negative first
    send_beat(make_encode(0, 0, 0, 100, -30000, 30000, 5));        // negative largest
    send_beat(make_encode(0, 0, 0, 0, 0, -32768, 32767));
    send_beat(make_encode(0, 0, 0, 32767, 32767, 32767, -32768));
    send_beat(make_encode(-1, 1, 0, 0, 0, 0, -32768));
    send_beat(make_decode(-32768, 32767, 0, 32'h0000_0000));
    send_beat(make_decode(-32767, 1, -1, 32'hFFFF_FFFF));  // field value above the bias
    send_beat(make_decode(0, 0, 0, {2'd0, 10'd511, 10'd511, 10'd511}));
    send_beat(make_decode(0, 0, 0, {2'd1, 10'd1022, 10'd0, 10'd511}));
    send_beat(make_decode(0, 0, 0, {2'd2, 10'd0, 10'd0, 10'd0}));
    send_beat(make_decode(0, 0, 0, {2'd3, 10'd1023, 10'd1022, 10'd1}));
    send_beat(make_decode(100, -100, 32767, {2'd3, 10'd600, 10'd420, 10'd511}));
    drain();

    // Each phase rewrites every register while the block is idle, then
    // streams random beats. The third phase runs without any idling.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          foreach (setting[i]) setting[i] = 32'hFFFF_FFFF;
        end
        1: begin
          foreach (setting[i]) setting[i] = 32'd1;
        end
        3: begin
          setting[REG_POSITION_SCALE]  = 32'd2097152;
          setting[REG_METRES_PER_CODE] = 32'd2048;
          setting[REG_ROTATION_SCALE]  = 32'd47361536;
          setting[REG_UNIT_PER_CODE]   = 32'd5943275;
        end
        default: begin
          setting[REG_POSITION_SCALE]  = $urandom_range(1, 32'h0100_0000);
          setting[REG_METRES_PER_CODE] = $urandom_range(1, 32'h0001_0000);
          setting[REG_ROTATION_SCALE]  = $urandom_range(32'h0100_0000, 32'h0400_0000);
          setting[REG_UNIT_PER_CODE]   = $urandom;
        end
      endcase
      foreach (setting[i]) write_reg(i, setting[i]);
      calm = (phase == 2);
      for (int n = 0; n < PHASE_BEATS; n++) send_beat(random_beat());
      calm = 1'b0;
      drain();
    end

    $display("Covered %0d encode and %0d decode beats over %0d register writes,",
             n_encode, n_decode, n_writes);
    $display("with %0d output beats checked and one long output stall.", sb.n_checked);
    if (sb.errors == 0) begin
      $display("tb_transform_quantize_codec_top: clean");
    end else begin
      $display("tb_transform_quantize_codec_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tqc_pkg.sv
rtl/tqc_isqrt.sv
rtl/tqc_div_lane.sv
rtl/tqc_delay.sv
rtl/transform_quantize_codec_top.sv
rtl/tqc_checker.sv
verif/tb_transform_quantize_codec_top.sv
